[sv/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Types, constants and step functions for the rotation matrix to quaternion
// pipeline: Q2.14 payload structs, square root and divider step helpers.
// ----------------------------------------------------------------------------
package rmq_pkg;

   // widths of the fixed-point values
   localparam int QW     = 16;   // Q2.14 entry and result
   localparam int TrW    = 18;   // trace of three entries
   localparam int RadSW  = 19;   // signed radicand
   localparam int RadW   = 18;   // clamped radicand
   localparam int NumW   = 17;   // off-diagonal sum or difference
   localparam int SqW    = 32;   // square root operand
   localparam int RootW  = 16;   // square root result
   localparam int RemW   = 19;   // square root remainder
   localparam int DivNW  = 31;   // divider dividend
   localparam int DivW   = 17;   // divider divisor (four times the root)
   localparam int DRemW  = 17;   // divider remainder
   localparam int QuotW  = 16;   // divider quotient bits
   localparam int FracW  = 14;   // fraction bits of Q2.14
   localparam int RadShW = 12;   // radicand scaling before the root

   // pipeline shape
   localparam int Steps      = 4;                 // iterations per stage
   localparam int SqrtStages = RootW / Steps;
   localparam int DivStages  = QuotW / Steps;
   localparam int Lanes      = 3;
   localparam int Parts      = 4;
   localparam int Latency    = 3 + SqrtStages + DivStages;

   localparam logic signed [RadSW-1:0] QOne = 19'sd16384;

   typedef logic signed [QW-1:0]   q_type;
   typedef logic signed [NumW-1:0] num_type;

   // which quaternion part comes from the root
   typedef enum logic [1:0] {
      SEL_SCALAR,
      SEL_X,
      SEL_Y,
      SEL_Z
   } sel_type;

   typedef struct packed {
      q_type c0_r0;
      q_type c0_r1;
      q_type c0_r2;
      q_type c1_r0;
      q_type c1_r1;
      q_type c1_r2;
      q_type c2_r0;
      q_type c2_r1;
      q_type c2_r2;
   } req_type;

   typedef struct packed {
      q_type q_scalar;
      q_type q_x;
      q_type q_y;
      q_type q_z;
      logic  bad_matrix;
   } rsp_type;

   // numerators of the three non-root parts, in ascending part order
   typedef struct packed {
      sel_type                  sel;
      num_type [Lanes-1:0]      n;
   } side_type;

   typedef struct packed {
      logic [SqW-1:0]   v;
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
   } sq_type;

   typedef struct packed {
      side_type         side;
      logic [RootW-1:0] root;
   } sqrt_out_type;

   typedef struct packed {
      logic [QuotW-1:0] nb;
      logic [DRemW-1:0] rem;
      logic [QuotW-1:0] q;
   } dv_type;

   typedef struct packed {
      sel_type                     sel;
      logic [RootW-1:0]            root;
      logic [Lanes-1:0]            neg;
      logic [Lanes-1:0]            ovf;
      logic [Lanes-1:0][QuotW-1:0] q;
   } div_out_type;

   // one digit of the bitwise square root
   function automatic sq_type sqrt_step(input sq_type s);
      logic [RemW-1:0] rt;
      logic [RemW-1:0] trial;
      sq_type          r;
      rt    = {s.rem[RemW-3:0], s.v[SqW-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      r.v   = {s.v[SqW-3:0], 2'b00};
      if (rt >= trial) begin
         r.rem  = rt - trial;
         r.root = {s.root[RootW-2:0], 1'b1};
      end else begin
         r.rem  = rt;
         r.root = {s.root[RootW-2:0], 1'b0};
      end
      return r;
   endfunction

   // one bit of the restoring divider
   function automatic dv_type div_step(input dv_type s, input logic [DivW-1:0] d);
      logic [DRemW:0] rt;
      dv_type         r;
      rt   = {s.rem, s.nb[QuotW-1]};
      r.nb = {s.nb[QuotW-2:0], 1'b0};
      if (rt >= {1'b0, d}) begin
         r.rem = DRemW'(rt - {1'b0, d});
         r.q   = {s.q[QuotW-2:0], 1'b1};
      end else begin
         r.rem = rt[DRemW-1:0];
         r.q   = {s.q[QuotW-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

[sv/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix (three columns of Q2.14 entries) to unit quaternion in
// Q2.14 by Shepperd's method, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a matrix on req_data. busy is always low, so a
//   transaction is taken on every clock edge at which start is high, one
//   matrix per cycle sustained.
//   Each result appears on rsp_data for one cycle, marked by rsp_valid;
//   results leave in order. The pipeline is one front stage (trace,
//   branch, radicand), four square root stages of four digits each,
//   one divider set-up stage, four divider stages of four quotient bits
//   each, and the output register.
//   bad_matrix is set, with all parts zero, when the root is zero.
//   The receiver cannot stall, so nothing is ever held back.
//   Synchronous reset empties the pipeline: results of transactions in
//   flight are dropped and rsp_valid is low until new work arrives.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rmq_pkg::req_type req_data,
   output logic             rsp_valid,
   output rmq_pkg::rsp_type rsp_data
);
   import rmq_pkg::*;

   logic         prep_valid;
   side_type     prep_side;
   sq_type       prep_sq;
   logic         sqrt_valid;
   sqrt_out_type sqrt_data;
   logic         div_valid;
   div_out_type  div_data;

   logic         rsp_valid_ff;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   q_type        part [Parts];
   logic [1:0]   li;

   assign busy = 1'b0;

   rmq_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_data  (req_data),
      .valid_ff (prep_valid),
      .side_ff  (prep_side),
      .sq_ff    (prep_sq)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_side   (prep_side),
      .in_sq     (prep_sq),
      .out_valid (sqrt_valid),
      .out_data  (sqrt_data)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_data   (sqrt_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // signed, saturated value of one divider lane
   function automatic q_type lane_value(input logic neg, input logic ovf,
                                        input logic [QuotW-1:0] q);
      q_type r;
      if (ovf || q[QuotW-1]) begin
         r = neg ? q_type'(-32768) : q_type'(32767);
      end else begin
         r = neg ? QW'(-{1'b0, q[QuotW-2:0]}) : QW'({1'b0, q[QuotW-2:0]});
      end
      return r;
   endfunction

   // place the root and the quotients, zero on a bad matrix
   always_comb begin
      li = '0;
      for (int i = 0; i < Parts; i++) begin
         if (2'(i) == div_data.sel) begin
            part[i] = QW'(div_data.root);
         end else begin
            li = (2'(i) > div_data.sel) ? 2'(i - 1) : 2'(i);
            part[i] = lane_value(div_data.neg[li], div_data.ovf[li], div_data.q[li]);
         end
      end
      rsp_in.bad_matrix = (div_data.root == '0);
      if (rsp_in.bad_matrix) begin
         rsp_in.q_scalar = '0;
         rsp_in.q_x      = '0;
         rsp_in.q_y      = '0;
         rsp_in.q_z      = '0;
      end else begin
         rsp_in.q_scalar = part[0];
         rsp_in.q_x      = part[1];
         rsp_in.q_y      = part[2];
         rsp_in.q_z      = part[3];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every transaction gives a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_valid)
      else $error("result missing after transaction");

   // no result without a transaction that fixed latency earlier
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Latency))
      else $error("result without transaction");

   // a bad matrix gives an all-zero quaternion
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_matrix) |->
         (rsp_data.q_scalar == '0 && rsp_data.q_x == '0
          && rsp_data.q_y == '0 && rsp_data.q_z == '0))
      else $error("bad matrix with nonzero parts");

endmodule

[sv/rmq_prep.sv]
// ----------------------------------------------------------------------------
// rmq_prep
// Front stage: trace, branch choice, radicand clamp and off-diagonal
// numerators, registered for the square root pipeline.
// ----------------------------------------------------------------------------
module rmq_prep (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rmq_pkg::req_type in_data,
   output logic             valid_ff,
   output rmq_pkg::side_type side_ff,
   output rmq_pkg::sq_type  sq_ff
);
   import rmq_pkg::*;

   logic signed [TrW-1:0]   tr;
   logic signed [RadSW-1:0] rad_s;
   logic        [RadW-1:0]  rad_u;
   q_type                   dg;
   side_type                side_in;
   sq_type                  sq_in;

   // trace and branch selection, ties to the lower index
   always_comb begin
      tr = TrW'(in_data.c0_r0) + TrW'(in_data.c1_r1) + TrW'(in_data.c2_r2);
      side_in.n = '0;
      dg = in_data.c0_r0;
      if (tr >= TrW'(in_data.c0_r0) && tr >= TrW'(in_data.c1_r1)
          && tr >= TrW'(in_data.c2_r2)) begin
         side_in.sel  = SEL_SCALAR;
         side_in.n[0] = NumW'(in_data.c1_r2) - NumW'(in_data.c2_r1);
         side_in.n[1] = NumW'(in_data.c2_r0) - NumW'(in_data.c0_r2);
         side_in.n[2] = NumW'(in_data.c0_r1) - NumW'(in_data.c1_r0);
      end else if (in_data.c0_r0 >= in_data.c1_r1 && in_data.c0_r0 >= in_data.c2_r2) begin
         side_in.sel  = SEL_X;
         dg           = in_data.c0_r0;
         side_in.n[0] = NumW'(in_data.c1_r2) - NumW'(in_data.c2_r1);
         side_in.n[1] = NumW'(in_data.c1_r0) + NumW'(in_data.c0_r1);
         side_in.n[2] = NumW'(in_data.c2_r0) + NumW'(in_data.c0_r2);
      end else if (in_data.c1_r1 >= in_data.c2_r2) begin
         side_in.sel  = SEL_Y;
         dg           = in_data.c1_r1;
         side_in.n[0] = NumW'(in_data.c2_r0) - NumW'(in_data.c0_r2);
         side_in.n[1] = NumW'(in_data.c1_r0) + NumW'(in_data.c0_r1);
         side_in.n[2] = NumW'(in_data.c2_r1) + NumW'(in_data.c1_r2);
      end else begin
         side_in.sel  = SEL_Z;
         dg           = in_data.c2_r2;
         side_in.n[0] = NumW'(in_data.c0_r1) - NumW'(in_data.c1_r0);
         side_in.n[1] = NumW'(in_data.c2_r0) + NumW'(in_data.c0_r2);
         side_in.n[2] = NumW'(in_data.c2_r1) + NumW'(in_data.c1_r2);
      end
      // radicand, clamped at zero
      if (side_in.sel == SEL_SCALAR) begin
         rad_s = QOne + RadSW'(tr);
      end else begin
         rad_s = QOne - RadSW'(tr) + (RadSW'(dg) <<< 1);
      end
      rad_u = rad_s[RadSW-1] ? '0 : rad_s[RadW-1:0];
      sq_in.v    = {(SqW - RadW - RadShW)'(0), rad_u, RadShW'(0)};
      sq_in.rem  = '0;
      sq_in.root = '0;
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= side_in;
      sq_ff   <= sq_in;
   end

endmodule

[sv/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined bitwise square root, a few digits per stage, with the numerators
// and branch choice carried alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rmq_pkg::side_type     in_side,
   input  rmq_pkg::sq_type       in_sq,
   output logic                  out_valid,
   output rmq_pkg::sqrt_out_type out_data
);
   import rmq_pkg::*;

   logic     valid_ff [SqrtStages];
   side_type side_ff  [SqrtStages];
   sq_type   sq_ff    [SqrtStages];
   sq_type   sq_in    [SqrtStages];

   // digit iterations of each stage
   always_comb begin
      for (int s = 0; s < SqrtStages; s++) begin
         sq_in[s] = (s == 0) ? in_sq : sq_ff[(s == 0) ? 0 : s - 1];
         for (int k = 0; k < Steps; k++) begin
            sq_in[s] = sqrt_step(sq_in[s]);
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SqrtStages; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < SqrtStages; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
      side_ff[0] <= in_side;
      for (int s = 1; s < SqrtStages; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
      for (int s = 0; s < SqrtStages; s++) begin
         sq_ff[s] <= sq_in[s];
      end
   end

   assign out_valid     = valid_ff[SqrtStages-1];
   assign out_data.side = side_ff[SqrtStages-1];
   assign out_data.root = sq_ff[SqrtStages-1].root;

endmodule

[sv/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider: numerator in Q2.14 over four times
// the root, rounded to nearest, with an overflow flag for saturation.
// ----------------------------------------------------------------------------
module rmq_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rmq_pkg::sqrt_out_type in_data,
   output logic                  out_valid,
   output rmq_pkg::div_out_type  out_data
);
   import rmq_pkg::*;

   logic             valid_ff [DivStages+1];
   sel_type          sel_ff   [DivStages+1];
   logic [RootW-1:0] root_ff  [DivStages+1];
   logic [Lanes-1:0] neg_ff   [DivStages+1];
   logic [Lanes-1:0] ovf_ff   [DivStages+1];
   logic [DivW-1:0]  d_ff     [DivStages+1];
   dv_type           dv_ff    [DivStages+1][Lanes];
   dv_type           dv_in    [DivStages+1][Lanes];

   logic [Lanes-1:0]  neg_in;
   logic [Lanes-1:0]  ovf_in;
   logic [DivW-1:0]   d_in;
   logic [NumW-1:0]   mag [Lanes];
   logic [DivNW-1:0]  dividend [Lanes];

   // operand set-up: magnitude, rounding offset, overflow check
   always_comb begin
      d_in = {in_data.root[DivW-3:0], 2'b00};
      for (int l = 0; l < Lanes; l++) begin
         neg_in[l]   = in_data.side.n[l][NumW-1];
         mag[l]      = neg_in[l] ? NumW'(-in_data.side.n[l]) : NumW'(in_data.side.n[l]);
         dividend[l] = DivNW'({mag[l], FracW'(0)}) + DivNW'({in_data.root, 1'b0});
         ovf_in[l]   = DivW'(dividend[l][DivNW-1:QuotW]) >= d_in;
         dv_in[0][l].nb  = dividend[l][QuotW-1:0];
         dv_in[0][l].rem = DRemW'(dividend[l][DivNW-1:QuotW]);
         dv_in[0][l].q   = '0;
      end
      // quotient bits, a few per stage
      for (int s = 1; s <= DivStages; s++) begin
         for (int l = 0; l < Lanes; l++) begin
            dv_in[s][l] = dv_ff[s-1][l];
            for (int k = 0; k < Steps; k++) begin
               dv_in[s][l] = div_step(dv_in[s][l], d_ff[s-1]);
            end
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DivStages; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= DivStages; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
      sel_ff[0]  <= in_data.side.sel;
      root_ff[0] <= in_data.root;
      neg_ff[0]  <= neg_in;
      ovf_ff[0]  <= ovf_in;
      d_ff[0]    <= d_in;
      for (int s = 1; s <= DivStages; s++) begin
         sel_ff[s]  <= sel_ff[s-1];
         root_ff[s] <= root_ff[s-1];
         neg_ff[s]  <= neg_ff[s-1];
         ovf_ff[s]  <= ovf_ff[s-1];
         d_ff[s]    <= d_ff[s-1];
      end
      for (int s = 0; s <= DivStages; s++) begin
         for (int l = 0; l < Lanes; l++) begin
            dv_ff[s][l] <= dv_in[s][l];
         end
      end
   end

   // last stage out
   always_comb begin
      out_valid     = valid_ff[DivStages];
      out_data.sel  = sel_ff[DivStages];
      out_data.root = root_ff[DivStages];
      out_data.neg  = neg_ff[DivStages];
      out_data.ovf  = ovf_ff[DivStages];
      for (int l = 0; l < Lanes; l++) begin
         out_data.q[l] = dv_ff[DivStages][l].q;
      end
   end

endmodule
